// ----- src/fcpu_pkg.sv -----
// Shared types, constants and a helper function for the fly camera pose core.
package fcpu_pkg;

    localparam int ATAN_COUNT = 24;
    localparam int ATAN_IW    = 5;

    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [15:0] ONE_Q14  = 16'sd16384;

    typedef logic [31:0] t_atan_tab [ATAN_COUNT];

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam t_atan_tab ATAN_TURN32 = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    typedef enum logic [2:0] {
        OP_FORWARD  = 3'd0,
        OP_BACKWARD = 3'd1,
        OP_RIGHT    = 3'd2,
        OP_LEFT     = 3'd3,
        OP_UP       = 3'd4,
        OP_DOWN     = 3'd5,
        OP_LOOK     = 3'd6,
        OP_RESERVED = 3'd7
    } t_op;

    localparam logic CFG_SPEED_GAIN = 1'b0;
    localparam logic CFG_LOOK_GAIN  = 1'b1;

    typedef struct packed {
        logic signed [15:0] c;
        logic signed [15:0] s;
    } t_trig;

    // Clamp a value to the closed range of a Q1.14 unit component.
    function automatic logic signed [15:0] clamp_q14(input logic signed [35:0] v);
        logic signed [15:0] r;
        if (v > 36'sd16384) begin
            r = ONE_Q14;
        end else if (v < -36'sd16384) begin
            r = -ONE_Q14;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- src/fcpu_cordic.sv -----
// Iterative rotation-mode CORDIC giving the cosine and sine of an angle in Q1.14.
module fcpu_cordic #(
    parameter int ANGLE_BITS   = 24,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output logic                  o_done,
    output fcpu_pkg::t_trig       o_trig
);
    import fcpu_pkg::*;

    localparam int IW = $clog2(CORDIC_STEPS);
    localparam logic [ANGLE_BITS-1:0] EIGHTH = {3'b001, {(ANGLE_BITS-3){1'b0}}};

    logic [ANGLE_BITS-1:0]        turned;
    logic signed [ANGLE_BITS-2:0] resid;
    logic signed [33:0]           z0;
    logic signed [33:0]           dx, dy, atan_i;
    logic signed [33:0]           x_rnd, y_rnd;
    logic signed [15:0]           cq, sq;

    logic signed [33:0] r_x, r_y, r_z;
    logic [1:0]         r_q;
    logic [IW-1:0]      r_i;
    logic               r_busy;
    logic               r_done;

    // Fold the angle into a quadrant and a residual within one eighth turn.
    always_comb begin
        turned = i_angle + EIGHTH;
        resid  = $signed({1'b0, turned[ANGLE_BITS-3:0]})
               - $signed({2'b01, {(ANGLE_BITS-3){1'b0}}});
        z0     = 34'(resid) <<< (32 - ANGLE_BITS);
    end

    always_comb begin
        dx     = r_y >>> r_i;
        dy     = r_x >>> r_i;
        atan_i = $signed({2'b00, ATAN_TURN32[ATAN_IW'(r_i)]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= CORDIC_K;
                r_y    <= '0;
                r_z    <= z0;
                r_q    <= turned[ANGLE_BITS-1:ANGLE_BITS-2];
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!r_z[33]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_i;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_i;
                end
                r_i <= r_i + 1'b1;
                if (r_i == IW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Round to Q1.14 and map back to the original quadrant.
    always_comb begin
        x_rnd = r_x + 34'sd32768;
        y_rnd = r_y + 34'sd32768;
        cq    = clamp_q14(36'($signed(x_rnd[33:16])));
        sq    = clamp_q14(36'($signed(y_rnd[33:16])));
        unique case (r_q)
            2'd0: begin
                o_trig.c = cq;
                o_trig.s = sq;
            end
            2'd1: begin
                o_trig.c = -sq;
                o_trig.s = cq;
            end
            2'd2: begin
                o_trig.c = -cq;
                o_trig.s = -sq;
            end
            default: begin
                o_trig.c = sq;
                o_trig.s = -cq;
            end
        endcase
    end

    assign o_done = r_done;

endmodule

// ----- src/fly_camera_pose_update_core.sv -----
// Top level of the fly camera pose core: command sequencer, shared multiplier and pose state.
//
// Usage:
// - Input words carry an opcode (forward, backward, right, left, up, down, look),
//   a time step for moves and two mouse offsets for look. A word is taken when
//   i_valid and o_ready are both high; o_ready is high only while the core idles.
// - Every input word yields exactly one output word: the position and front
//   vector after the command. It is offered on o_valid until i_ready takes it.
// - Forward, backward, up and down need no CORDIC pass; right and left need
//   one CORDIC pass on the heading; look needs two CORDIC passes plus the
//   angle updates and two front products. The reserved opcode goes straight
//   to the final step. The shared CORDIC unit runs one iteration per cycle.
// - One word is in flight at a time. If the receiver stalls, the finished
//   word waits in the output register and the core holds its final step
//   until the slot frees, so nothing is lost or repeated.
// - Synchronous active-low reset restores the gains (640 and 5341), zero
//   angles, position (1.5, 2.0, -7.0) and front vector (1, 0, 0).
// - User must write gains via i_cfg_we/i_cfg_idx/i_cfg_data only while idle; not enforced.
module fly_camera_pose_update_core #(
    parameter int ANGLE_BITS   = 24,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_opcode,
    input  logic [15:0]        i_time_step,
    input  logic signed [15:0] i_offset_x,
    input  logic signed [15:0] i_offset_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [15:0] o_dir_x,
    output logic signed [15:0] o_dir_y,
    output logic signed [15:0] o_dir_z
);
    import fcpu_pkg::*;

    // Pitch limit: 89 degrees in angle units.
    localparam logic [63:0] LIM64 = (64'd89 << ANGLE_BITS) / 64'd360;
    localparam logic signed [49:0] LIM = $signed(50'(LIM64));

    typedef enum logic [4:0] {
        S_IDLE, S_SPEED, S_SPEED_W, S_CW_RIGHT, S_MV_MUL, S_MV_RND, S_MV_ADD,
        S_LOOK_H, S_LOOK_E, S_LOOK_EW, S_CW_H, S_CW_E, S_MIX_X, S_MIX_Z,
        S_MIX_W, S_FIN
    } t_state;

    t_state r_state;

    logic [15:0]        r_speed_gain, r_look_gain;
    logic [ANGLE_BITS-1:0]        r_heading;
    logic signed [ANGLE_BITS-1:0] r_elev;
    logic signed [31:0] r_loc [3];
    logic signed [15:0] r_dir [3];
    logic signed [15:0] r_vec [3];
    logic [1:0]         r_k;
    t_op                r_op;
    logic [15:0]        r_dt;
    logic signed [15:0] r_ox, r_oy;
    logic [31:0]        r_s;
    logic signed [33:0] r_d;
    logic signed [49:0] r_prod;
    logic signed [15:0] r_ch, r_sh, r_ce;
    logic               r_ovalid;
    logic signed [31:0] r_out_pos [3];
    logic signed [15:0] r_out_dir [3];

    logic signed [16:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [49:0] neg_prod, e_sum, mix_sum;
    logic signed [33:0] d_next, loc_sum;
    logic signed [31:0] loc_sat;
    logic               cord_start, cord_done;
    logic [ANGLE_BITS-1:0] cord_angle;
    t_trig              cord_trig;

    fcpu_cordic #(
        .ANGLE_BITS  (ANGLE_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(cord_start),
        .i_angle(cord_angle),
        .o_done (cord_done),
        .o_trig (cord_trig)
    );

    // Operand selection for the one shared multiplier; its product is registered.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SPEED: begin
                mul_a = $signed({1'b0, r_speed_gain});
                mul_b = $signed({17'd0, r_dt});
            end
            S_MV_MUL: begin
                mul_a = 17'(r_vec[r_k]);
                mul_b = $signed({1'b0, r_s});
            end
            S_LOOK_H: begin
                mul_a = 17'(r_ox);
                mul_b = $signed({17'd0, r_look_gain});
            end
            S_LOOK_E: begin
                mul_a = 17'(r_oy);
                mul_b = $signed({17'd0, r_look_gain});
            end
            S_MIX_X: begin
                mul_a = 17'(r_ch);
                mul_b = 33'(r_ce);
            end
            S_MIX_Z: begin
                mul_a = 17'(r_sh);
                mul_b = 33'(r_ce);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // CORDIC is started on the heading for strafing and the first look pass,
    // and on the elevation for the second look pass.
    always_comb begin
        cord_start = ((r_state == S_SPEED_W) && (r_op == OP_RIGHT || r_op == OP_LEFT))
                  || (r_state == S_LOOK_EW)
                  || ((r_state == S_CW_H) && cord_done);
        cord_angle = (r_state == S_CW_H) ? r_elev : r_heading;
    end

    always_comb begin
        // Round the scaled component half away from zero.
        neg_prod = -r_prod;
        if (!r_prod[49]) begin
            d_next = 34'((r_prod + 50'sd2097152) >>> 22);
        end else begin
            d_next = -34'((neg_prod + 50'sd2097152) >>> 22);
        end
        loc_sum = r_op[0] ? (34'(r_loc[r_k]) - r_d) : (34'(r_loc[r_k]) + r_d);
        if (loc_sum > 34'sd2147483647) begin
            loc_sat = 32'sh7fffffff;
        end else if (loc_sum < -34'sd2147483648) begin
            loc_sat = 32'sh80000000;
        end else begin
            loc_sat = loc_sum[31:0];
        end
        e_sum   = 50'(r_elev) + r_prod;
        mix_sum = (r_prod + 50'sd8192) >>> 14;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ovalid     <= 1'b0;
            r_speed_gain <= 16'd640;
            r_look_gain  <= 16'd5341;
            r_heading    <= '0;
            r_elev       <= '0;
            r_loc[0]     <= 32'sd98304;
            r_loc[1]     <= 32'sd131072;
            r_loc[2]     <= -32'sd458752;
            r_dir[0]     <= ONE_Q14;
            r_dir[1]     <= '0;
            r_dir[2]     <= '0;
        end else begin
            // A finished pose enters the output register once it is free;
            // otherwise a taken word empties it.
            if (r_state == S_FIN && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SPEED_GAIN: r_speed_gain <= i_cfg_data;
                    CFG_LOOK_GAIN:  r_look_gain  <= i_cfg_data;
                    default:        r_look_gain  <= i_cfg_data;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op <= t_op'(i_opcode);
                        r_dt <= i_time_step;
                        r_ox <= i_offset_x;
                        r_oy <= i_offset_y;
                        if (t_op'(i_opcode) == OP_LOOK) begin
                            r_state <= S_LOOK_H;
                        end else if (t_op'(i_opcode) == OP_RESERVED) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_SPEED;
                        end
                    end
                end
                S_SPEED: r_state <= S_SPEED_W;
                S_SPEED_W: begin
                    r_s <= r_prod[31:0];
                    r_k <= '0;
                    if (r_op == OP_FORWARD || r_op == OP_BACKWARD) begin
                        r_vec[0] <= r_dir[0];
                        r_vec[1] <= r_dir[1];
                        r_vec[2] <= r_dir[2];
                        r_state  <= S_MV_MUL;
                    end else if (r_op == OP_UP || r_op == OP_DOWN) begin
                        r_vec[0] <= '0;
                        r_vec[1] <= ONE_Q14;
                        r_vec[2] <= '0;
                        r_state  <= S_MV_MUL;
                    end else begin
                        r_state <= S_CW_RIGHT;
                    end
                end
                S_CW_RIGHT: begin
                    if (cord_done) begin
                        // Right vector is (-sin yaw, 0, cos yaw).
                        r_vec[0] <= -cord_trig.s;
                        r_vec[1] <= '0;
                        r_vec[2] <= cord_trig.c;
                        r_state  <= S_MV_MUL;
                    end
                end
                S_MV_MUL: r_state <= S_MV_RND;
                S_MV_RND: begin
                    r_d     <= d_next;
                    r_state <= S_MV_ADD;
                end
                S_MV_ADD: begin
                    r_loc[r_k] <= loc_sat;
                    r_k        <= r_k + 2'd1;
                    r_state    <= (r_k == 2'd2) ? S_FIN : S_MV_MUL;
                end
                S_LOOK_H: r_state <= S_LOOK_E;
                S_LOOK_E: begin
                    // Heading wraps modulo one turn.
                    r_heading <= r_heading + r_prod[ANGLE_BITS-1:0];
                    r_state   <= S_LOOK_EW;
                end
                S_LOOK_EW: begin
                    // Pitch saturates at the limit.
                    if (e_sum > LIM) begin
                        r_elev <= LIM[ANGLE_BITS-1:0];
                    end else if (e_sum < -LIM) begin
                        r_elev <= -LIM[ANGLE_BITS-1:0];
                    end else begin
                        r_elev <= e_sum[ANGLE_BITS-1:0];
                    end
                    r_state <= S_CW_H;
                end
                S_CW_H: begin
                    if (cord_done) begin
                        r_ch    <= cord_trig.c;
                        r_sh    <= cord_trig.s;
                        r_state <= S_CW_E;
                    end
                end
                S_CW_E: begin
                    if (cord_done) begin
                        r_ce     <= cord_trig.c;
                        r_dir[1] <= cord_trig.s;
                        r_state  <= S_MIX_X;
                    end
                end
                S_MIX_X: r_state <= S_MIX_Z;
                S_MIX_Z: begin
                    r_dir[0] <= clamp_q14(mix_sum[35:0]);
                    r_state  <= S_MIX_W;
                end
                S_MIX_W: begin
                    r_dir[2] <= clamp_q14(mix_sum[35:0]);
                    r_state  <= S_FIN;
                end
                S_FIN: begin
                    // Wait here until the output register is free.
                    if (!r_ovalid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output word payload, loaded when the final step completes.
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && (!r_ovalid || i_ready)) begin
            r_out_pos[0] <= r_loc[0];
            r_out_pos[1] <= r_loc[1];
            r_out_pos[2] <= r_loc[2];
            r_out_dir[0] <= r_dir[0];
            r_out_dir[1] <= r_dir[1];
            r_out_dir[2] <= r_dir[2];
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_pos_x = r_out_pos[0];
    assign o_pos_y = r_out_pos[1];
    assign o_pos_z = r_out_pos[2];
    assign o_dir_x = r_out_dir[0];
    assign o_dir_y = r_out_dir[1];
    assign o_dir_z = r_out_dir[2];

endmodule

// ----- verif/fly_camera_pose_update_core_test.sv -----
// Self-checking testbench for the fly camera pose core: directed table, random words, gain phases.
module fly_camera_pose_update_core_test;
    import fcpu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Idle time allowed before a gain write: the longest command latency plus margin.
    localparam int SETTLE_CYCLES = 2 * 16 + 40;
    localparam int STALL_LIMIT   = 3000;
    localparam int PHASE_WORDS   = 320;
    localparam longint ANG_MASK  = (64'd1 << 24) - 1;
    localparam longint ANG_EIGHTH  = 64'd1 << 21;
    localparam longint ANG_QUARTER = 64'd1 << 22;
    localparam longint PITCH_LIMIT = (64'd89 << 24) / 360;
    localparam int NUM_ROWS = 22;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = CFG_SPEED_GAIN;
    logic [15:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_opcode = OP_RESERVED;
    logic [15:0]        i_time_step = '0;
    logic signed [15:0] i_offset_x = '0;
    logic signed [15:0] i_offset_y = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [15:0] o_dir_x, o_dir_y, o_dir_z;

    typedef struct {
        int pos [3];
        int dir [3];
    } t_pose;

    // One row of the directed table. Rows with a known pose carry it in want.
    typedef struct {
        t_op         op;
        logic [15:0] dt;
        logic [15:0] ox;
        logic [15:0] oy;
        bit          known;
        t_pose       want;
    } t_row;

    t_row   dir_rows [NUM_ROWS];
    t_pose  pose_queue [$];
    int     fail_count = 0;
    int     words_taken = 0;
    int     idle_cycles = 0;
    bit     stim_done = 1'b0;

    // Predictor copy of the pose and the gains.
    longint heading_q, elevation_q;
    longint location_q [3];
    int     front_q [3];
    int     speed_q, look_q;

    fly_camera_pose_update_core u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int clamp_unit(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return int'(v);
    endfunction

    // Rotation-mode CORDIC on one angle, reduced to a quadrant and a residual.
    function automatic void sin_cos(input longint ang, output int c, output int s);
        longint t, r, z, x, y, dx, dy;
        int q, cq, sq;
        t = ((ang & ANG_MASK) + ANG_EIGHTH) & ANG_MASK;
        q = int'((t >> 22) & 3);
        r = (t & (ANG_QUARTER - 1)) - ANG_EIGHTH;
        z = r * 256;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TURN32[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TURN32[i]);
            end
        end
        cq = clamp_unit((x + 32768) >>> 16);
        sq = clamp_unit((y + 32768) >>> 16);
        case (q)
            0: begin c = cq; s = sq; end
            1: begin c = -sq; s = cq; end
            2: begin c = -cq; s = -sq; end
            default: begin c = sq; s = -cq; end
        endcase
    endfunction

    function automatic int mul_unit(int a, int b);
        return clamp_unit((longint'(a) * longint'(b) + 8192) >>> 14);
    endfunction

    // Applies one command to the predictor and returns the pose after it.
    function automatic t_pose apply_command(t_op op, logic [15:0] dt,
                                            logic signed [15:0] ox,
                                            logic signed [15:0] oy);
        int vec [3];
        int ch, sh, ce, se;
        longint step, p, d, n, e;
        t_pose res;
        step = longint'(speed_q) * longint'(dt);
        if (op <= OP_DOWN) begin
            if (op <= OP_BACKWARD) begin
                vec = front_q;
            end else if (op <= OP_LEFT) begin
                sin_cos(heading_q, ch, sh);
                vec = '{-sh, 0, ch};
            end else begin
                vec = '{0, 16384, 0};
            end
            for (int k = 0; k < 3; k++) begin
                p = longint'(vec[k]) * step;
                d = (p >= 0) ? (p + (64'd1 << 21)) >>> 22 : -((-p + (64'd1 << 21)) >>> 22);
                n = op[0] ? location_q[k] - d : location_q[k] + d;
                if (n > 64'sd2147483647) n = 64'sd2147483647;
                if (n < -64'sd2147483648) n = -64'sd2147483648;
                location_q[k] = n;
            end
        end else if (op == OP_LOOK) begin
            heading_q = (heading_q + longint'(ox) * longint'(look_q)) & ANG_MASK;
            e = elevation_q + longint'(oy) * longint'(look_q);
            if (e > PITCH_LIMIT) e = PITCH_LIMIT;
            if (e < -PITCH_LIMIT) e = -PITCH_LIMIT;
            elevation_q = e;
            sin_cos(heading_q, ch, sh);
            sin_cos(elevation_q, ce, se);
            front_q = '{mul_unit(ch, ce), se, mul_unit(sh, ce)};
        end
        for (int k = 0; k < 3; k++) begin
            res.pos[k] = int'(location_q[k]);
            res.dir[k] = front_q[k];
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
        fail_count++;
    endtask

    task automatic compare_pose(string tag, t_pose want);
        if (o_pos_x !== want.pos[0]) report_mismatch({tag, " pos_x"}, o_pos_x, want.pos[0]);
        if (o_pos_y !== want.pos[1]) report_mismatch({tag, " pos_y"}, o_pos_y, want.pos[1]);
        if (o_pos_z !== want.pos[2]) report_mismatch({tag, " pos_z"}, o_pos_z, want.pos[2]);
        if (o_dir_x !== 16'(want.dir[0])) report_mismatch({tag, " dir_x"}, o_dir_x, want.dir[0]);
        if (o_dir_y !== 16'(want.dir[1])) report_mismatch({tag, " dir_y"}, o_dir_y, want.dir[1]);
        if (o_dir_z !== 16'(want.dir[2])) report_mismatch({tag, " dir_z"}, o_dir_z, want.dir[2]);
    endtask

    // Monitor: predicts on each accepted input word, checks each accepted output word.
    // Directed rows with a known pose are also checked against the typed-in values,
    // which works because exactly one word is in flight at a time.
    int result_count = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            speed_q = 640;
            look_q = 5341;
            heading_q = 0;
            elevation_q = 0;
            location_q = '{98304, 131072, -458752};
            front_q = '{16384, 0, 0};
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SPEED_GAIN) speed_q = i_cfg_data;
                else look_q = i_cfg_data;
            end
            if (i_valid && o_ready) begin
                pose_queue.push_back(apply_command(t_op'(i_opcode), i_time_step,
                                                   i_offset_x, i_offset_y));
                words_taken++;
            end
            if (o_valid && i_ready) begin
                if (pose_queue.size() == 0) begin
                    report_mismatch("unexpected word", 0, 0);
                end else begin
                    compare_pose("pose", pose_queue.pop_front());
                end
                if (result_count < NUM_ROWS && dir_rows[result_count].known)
                    compare_pose("table", dir_rows[result_count].want);
                result_count++;
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL fly_camera_pose_update_core");
                $finish;
            end
        end
    end

    // Receiver: a random stall, which may be zero, before each word.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_word(t_op op, logic [15:0] dt, logic [15:0] ox, logic [15:0] oy,
                             int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_time_step <= dt;
        i_offset_x <= ox;
        i_offset_y <= oy;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pose_queue.size() != 0 || result_count != words_taken) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gain(logic idx, logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_offset();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($signed($urandom_range(0, 64)) - 32);
            2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic t_row make_row(t_op op, logic [15:0] dt, logic [15:0] ox,
                                      logic [15:0] oy, bit known);
        t_row r;
        r.op = op; r.dt = dt; r.ox = ox; r.oy = oy; r.known = known;
        r.want.pos = '{98304, 131072, -458752};
        r.want.dir = '{16384, 0, 0};
        return r;
    endfunction

    initial begin
        static logic [15:0] speed_set [6] =
            '{16'd0, 16'd65535, 16'd640, 16'd1, 16'd65535, 16'd300};
        static logic [15:0] look_set  [6] =
            '{16'd65535, 16'd0, 16'd5341, 16'd1, 16'd65535, 16'd20000};
        t_op favored;
        t_op op;
        logic [15:0] dt;

        // Rows that leave the reset pose untouched carry it as a known result.
        dir_rows[0]  = make_row(OP_RESERVED, 16'hFFFF, 16'h7FFF, 16'h8000, 1'b1);
        dir_rows[1]  = make_row(OP_FORWARD, 16'd0, 16'h0, 16'h0, 1'b1);
        dir_rows[2]  = make_row(OP_BACKWARD, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
        dir_rows[3]  = make_row(OP_UP, 16'd0, 16'h0, 16'h0, 1'b1);
        dir_rows[4]  = make_row(OP_FORWARD, 16'hFFFF, 16'h0, 16'h0, 1'b0);
        dir_rows[5]  = make_row(OP_BACKWARD, 16'hFFFF, 16'h0, 16'h0, 1'b0);
        dir_rows[6]  = make_row(OP_RIGHT, 16'hFFFF, 16'h0, 16'h0, 1'b0);
        dir_rows[7]  = make_row(OP_LEFT, 16'h8000, 16'h0, 16'h0, 1'b0);
        dir_rows[8]  = make_row(OP_UP, 16'hFFFF, 16'h0, 16'h0, 1'b0);
        dir_rows[9]  = make_row(OP_DOWN, 16'h0001, 16'h0, 16'h0, 1'b0);
        dir_rows[10] = make_row(OP_LOOK, 16'h0, 16'h0, 16'h0, 1'b0);
        // Pitch driven past the upper and lower limit, heading wrapped both ways.
        dir_rows[11] = make_row(OP_LOOK, 16'h0, 16'h7FFF, 16'h7FFF, 1'b0);
        dir_rows[12] = make_row(OP_LOOK, 16'h0, 16'h8000, 16'h8000, 1'b0);
        dir_rows[13] = make_row(OP_LOOK, 16'h0, 16'h0100, 16'h0050, 1'b0);
        dir_rows[14] = make_row(OP_FORWARD, 16'h4000, 16'h0, 16'h0, 1'b0);
        dir_rows[15] = make_row(OP_RIGHT, 16'h1234, 16'h0, 16'h0, 1'b0);
        dir_rows[16] = make_row(OP_LOOK, 16'hFFFF, 16'hFF00, 16'hFFC0, 1'b0);
        dir_rows[17] = make_row(OP_LEFT, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b0);
        dir_rows[18] = make_row(OP_LOOK, 16'h0, 16'h0400, 16'h0000, 1'b0);
        dir_rows[19] = make_row(OP_BACKWARD, 16'hABCD, 16'h0, 16'h0, 1'b0);
        dir_rows[20] = make_row(OP_RESERVED, 16'h0, 16'h0, 16'h0, 1'b0);
        dir_rows[21] = make_row(OP_DOWN, 16'hFFFF, 16'h5555, 16'hAAAA, 1'b0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            send_word(dir_rows[r].op, dir_rows[r].dt, dir_rows[r].ox, dir_rows[r].oy,
                      $urandom_range(0, 7));
        drain();

        // Random phases, each under its own pair of gains. Each phase leans toward one
        // command so that the position can run into saturation at high speed.
        for (int ph = 0; ph < 6; ph++) begin
            write_gain(CFG_SPEED_GAIN, speed_set[ph]);
            write_gain(CFG_LOOK_GAIN, (ph == 5) ? 16'($urandom_range(0, 65535)) : look_set[ph]);
            favored = t_op'($urandom_range(0, 5));
            for (int w = 0; w < PHASE_WORDS; w++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: op = favored;
                    4:          op = OP_RESERVED;
                    5, 6:       op = OP_LOOK;
                    default:    op = t_op'($urandom_range(0, 6));
                endcase
                dt = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                          : 16'($urandom_range(0, 255));
                send_word(op, dt, rand_offset(), rand_offset(),
                          (w % 64 < 16) ? 0 : $urandom_range(0, 7));
            end
            drain();
        end

        if (fail_count == 0 && pose_queue.size() == 0) begin
            $display("PASS fly_camera_pose_update_core");
        end else begin
            $display("FAIL fly_camera_pose_update_core");
        end
        $finish;
    end

endmodule
